// ===== hdl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, character codes and helpers of the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int unsigned RunMax   = 12;
    localparam int unsigned CountW   = $clog2(RunMax + 1);

    localparam logic [7:0] ChQuote   = 8'h22;
    localparam logic [7:0] ChBslash  = 8'h5C;
    localparam logic [7:0] ChLowU    = 8'h75;
    localparam logic [7:0] ChLowB    = 8'h62;
    localparam logic [7:0] ChLowF    = 8'h66;
    localparam logic [7:0] ChLowN    = 8'h6E;
    localparam logic [7:0] ChLowR    = 8'h72;
    localparam logic [7:0] ChLowT    = 8'h74;
    localparam logic [7:0] CtlBs     = 8'h08;
    localparam logic [7:0] CtlTab    = 8'h09;
    localparam logic [7:0] CtlNl     = 8'h0A;
    localparam logic [7:0] CtlFf     = 8'h0C;
    localparam logic [7:0] CtlCr     = 8'h0D;
    localparam logic [7:0] CtlLimit  = 8'h20;
    localparam logic [7:0] AsciiLimit = 8'h80;

    localparam logic [15:0] SurrHiBase = 16'hD800;
    localparam logic [15:0] SurrLoBase = 16'hDC00;
    localparam logic [20:0] PlaneOne   = 21'h10000;

    typedef struct packed {
        logic        discarding;
        logic [1:0]  bytes_remaining;
        logic [2:0]  sequence_length;
        logic [20:0] code_point_acc;
        logic [23:0] held_bytes;
        logic [7:0]  lead_byte;
    } dec_state_t;

    typedef struct packed {
        logic [RunMax-1:0][7:0] bytes;
        logic [CountW-1:0]      count;
        logic                   err;
        logic                   eos;
    } run_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end else begin
            res = 8'h57 + {4'd0, nib};
        end
        return res;
    endfunction

    function automatic logic [5:0][7:0] u_escape(input logic [15:0] unit);
        logic [5:0][7:0] res;
        res[0] = ChBslash;
        res[1] = ChLowU;
        res[2] = hex_char(unit[15:12]);
        res[3] = hex_char(unit[11:8]);
        res[4] = hex_char(unit[7:4]);
        res[5] = hex_char(unit[3:0]);
        return res;
    endfunction

endpackage

// ===== hdl/jse_decode.sv =====
// ----------------------------------------------------------------------------
// jse_decode
// per-byte escape and utf-8 decode logic: next decoder state and output run
// ----------------------------------------------------------------------------
module jse_decode (
    input  jse_pkg::dec_state_t st,
    input  logic [7:0]          in_byte,
    input  logic                last,
    input  logic                escape_non_ascii,
    output jse_pkg::dec_state_t st_next,
    output jse_pkg::run_t       run
);
    import jse_pkg::*;

    logic [7:0]  esc;
    logic        fail;
    logic [2:0]  len;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] acc_new;
    logic [1:0]  rem_new;
    logic [20:0] cp_off;
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;

    always_comb begin
        st_next = st;
        run     = '0;
        fail    = 1'b0;
        esc     = 8'h00;
        len     = 3'd0;
        lo      = 8'h80;
        hi      = 8'hBF;
        acc_new = {st.code_point_acc[14:0], in_byte[5:0]};
        rem_new = st.bytes_remaining - 2'd1;
        cp_off  = acc_new - PlaneOne;
        unit_hi = SurrHiBase + {6'd0, cp_off[19:10]};
        unit_lo = SurrLoBase + {6'd0, cp_off[9:0]};

        if (st.discarding) begin
            if (last) begin
                st_next.discarding = 1'b0;
            end
        end else if (st.bytes_remaining == 2'd0) begin
            unique case (in_byte)
                ChQuote:  esc = ChQuote;
                ChBslash: esc = ChBslash;
                CtlBs:    esc = ChLowB;
                CtlFf:    esc = ChLowF;
                CtlNl:    esc = ChLowN;
                CtlCr:    esc = ChLowR;
                CtlTab:   esc = ChLowT;
                default:  esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
                run.bytes[0] = ChBslash;
                run.bytes[1] = esc;
                run.count    = CountW'(2);
            end else if (in_byte < CtlLimit) begin
                run.bytes[5:0] = u_escape({8'h00, in_byte});
                run.count      = CountW'(6);
            end else if (in_byte < AsciiLimit) begin
                run.bytes[0] = in_byte;
                run.count    = CountW'(1);
            end else begin
                priority if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
                    len = 3'd2;
                    st_next.code_point_acc = {16'd0, in_byte[4:0]};
                end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
                    len = 3'd3;
                    st_next.code_point_acc = {17'd0, in_byte[3:0]};
                end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
                    len = 3'd4;
                    st_next.code_point_acc = {18'd0, in_byte[2:0]};
                end else begin
                    fail = 1'b1;
                end
                if (last) begin
                    fail = 1'b1;
                end
                st_next.sequence_length = len;
                st_next.bytes_remaining = 2'(len - 3'd1);
                st_next.lead_byte       = in_byte;
                st_next.held_bytes      = {16'd0, in_byte};
            end
        end else begin
            if ({1'b0, st.bytes_remaining} + 3'd1 == st.sequence_length) begin
                priority case (st.lead_byte)
                    8'hE0:   lo = 8'hA0;
                    8'hED:   hi = 8'h9F;
                    8'hF0:   lo = 8'h90;
                    8'hF4:   hi = 8'h8F;
                    default: lo = 8'h80;
                endcase
            end
            if (in_byte < lo || in_byte > hi) begin
                fail = 1'b1;
            end else if (rem_new != 2'd0) begin
                if (last) begin
                    fail = 1'b1;
                end
                st_next.code_point_acc  = acc_new;
                st_next.bytes_remaining = rem_new;
                st_next.held_bytes      = {st.held_bytes[15:0], in_byte};
            end else begin
                if (escape_non_ascii) begin
                    if (acc_new[20:16] == 5'd0) begin
                        run.bytes[5:0] = u_escape(acc_new[15:0]);
                        run.count      = CountW'(6);
                    end else begin
                        run.bytes[5:0]  = u_escape(unit_hi);
                        run.bytes[11:6] = u_escape(unit_lo);
                        run.count       = CountW'(12);
                    end
                end else begin
                    case (st.sequence_length)
                        3'd2: begin
                            run.bytes[0] = st.held_bytes[7:0];
                            run.bytes[1] = in_byte;
                            run.count    = CountW'(2);
                        end
                        3'd3: begin
                            run.bytes[0] = st.held_bytes[15:8];
                            run.bytes[1] = st.held_bytes[7:0];
                            run.bytes[2] = in_byte;
                            run.count    = CountW'(3);
                        end
                        3'd4: begin
                            run.bytes[0] = st.held_bytes[23:16];
                            run.bytes[1] = st.held_bytes[15:8];
                            run.bytes[2] = st.held_bytes[7:0];
                            run.bytes[3] = in_byte;
                            run.count    = CountW'(4);
                        end
                        default: begin
                            run.bytes[0] = in_byte;
                            run.count    = CountW'(1);
                        end
                    endcase
                end
                st_next.bytes_remaining = 2'd0;
                st_next.sequence_length = 3'd0;
                st_next.code_point_acc  = '0;
                st_next.held_bytes      = '0;
                st_next.lead_byte       = '0;
            end
        end

        if (!st.discarding && run.count != '0) begin
            run.eos = last;
        end

        if (fail) begin
            st_next            = '0;
            st_next.discarding = !last;
            run                = '0;
            run.count          = CountW'(1);
            run.err            = 1'b1;
            run.eos            = 1'b1;
        end
    end

endmodule

// ===== hdl/jse_emit.sv =====
// ----------------------------------------------------------------------------
// jse_emit
// result register: holds one run of escaped bytes and sends them out in order
// ----------------------------------------------------------------------------
module jse_emit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load_en,
    input  jse_pkg::run_t run_in,
    output logic          free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // out_byte
    output logic          m_tlast,   // last_of_run
    output logic [1:0]    m_tuser    // error, end_of_string
);
    import jse_pkg::*;

    logic [RunMax-1:0][7:0] bytes_reg;
    logic [RunMax-1:0][7:0] bytes_next;
    logic [CountW-1:0]      rem_reg;
    logic [CountW-1:0]      rem_next;
    logic                   err_reg;
    logic                   err_next;
    logic                   eos_reg;
    logic                   eos_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   final_word;
    logic                   take;

    assign final_word = rem_reg == CountW'(1);
    assign take       = valid_reg && m_tready;
    assign free       = !valid_reg || (take && final_word);

    always_comb begin
        bytes_next = bytes_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        eos_next   = eos_reg;
        valid_next = valid_reg;
        if (take) begin
            bytes_next = bytes_reg >> 8;
            rem_next   = rem_reg - CountW'(1);
            if (final_word) begin
                valid_next = 1'b0;
            end
        end
        if (load_en) begin
            bytes_next = run_in.bytes;
            rem_next   = run_in.count;
            err_next   = run_in.err;
            eos_next   = run_in.eos;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
        bytes_reg <= bytes_next;
        err_reg   <= err_next;
        eos_reg   <= eos_next;
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = bytes_reg[0];
    assign m_tlast    = final_word;
    assign m_tuser[0] = err_reg;
    assign m_tuser[1] = eos_reg && final_word;

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> rem_reg != '0 && rem_reg <= CountW'(RunMax))
        else $error("run length out of range");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |-> free)
        else $error("run loaded over a pending run");
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !final_word |=> valid_reg && rem_reg == $past(rem_reg) - CountW'(1))
        else $error("run cut short");
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && err_reg |-> final_word && bytes_reg[0] == 8'h00)
        else $error("error result not a single zero word");

endmodule

// ===== hdl/json_string_escaper.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper
// escapes the body of a json string one input byte at a time
// ----------------------------------------------------------------------------
// One string byte enters per accepted word and its escaped output appears
// on the result side from the next cycle, one byte per cycle while m_tready is
// high; plain ASCII sustains that rate, longer escapes hold the input until
// their run has left, and bytes opening or continuing a UTF-8 sequence give
// no output. The result register holding one run of output bytes sets the
// rate: the next byte is taken in the cycle that the last byte of the run
// leaves. An error word (zero byte, tuser bits error and end_of_string set)
// reports bad or truncated UTF-8; the rest of that string up to s_tlast is
// dropped. The user writes escape_non_ascii through cfg_wr_en while the
// block is idle, not enforced by the block; it resets to copy-raw mode.
module json_string_escaper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,  // escape_non_ascii
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // in_byte
    input  logic       s_tlast,      // last_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // out_byte
    output logic       m_tlast,      // last_of_run
    output logic [1:0] m_tuser       // error, end_of_string
);
    import jse_pkg::*;

    dec_state_t st_reg;
    dec_state_t st_next;
    run_t       run;
    logic       esc_mode_reg;
    logic       accept;
    logic       free;
    logic       load_en;

    jse_decode u_decode (
        .st               (st_reg),
        .in_byte          (s_tdata),
        .last             (s_tlast),
        .escape_non_ascii (esc_mode_reg),
        .st_next          (st_next),
        .run              (run)
    );

    assign s_tready = free;
    assign accept   = s_tvalid && s_tready;
    assign load_en  = accept && run.count != '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            esc_mode_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_reg <= st_next;
            end
            if (cfg_wr_en) begin
                esc_mode_reg <= cfg_wr_data;
            end
        end
    end

    jse_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (load_en),
        .run_in   (run),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_discard_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.discarding |-> run.count == '0)
        else $error("output while dropping a string");
    a_seq_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.bytes_remaining != 2'd0 |->
            {1'b0, st_reg.bytes_remaining} < st_reg.sequence_length && !st_reg.discarding)
        else $error("sequence state inconsistent");
    a_err_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && run.err |=> st_reg.bytes_remaining == 2'd0
            && st_reg.discarding == !$past(s_tlast))
        else $error("error did not reset the decoder");

endmodule

// ===== test/escape_checker.sv =====
// ----------------------------------------------------------------------------
// escape_checker
// watches both streams of the json string escaper, predicts every escaped
// word from the accepted string bytes and compares it field by field
// ----------------------------------------------------------------------------
module escape_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,      // in_byte
    input  logic       s_tlast,      // last_of_string
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,      // out_byte
    input  logic       m_tlast,      // last_of_run
    input  logic [1:0] m_tuser,      // error, end_of_string
    output int         fail_count,
    output int         pending,
    output int         words_in,
    output int         words_out,
    output int         errors_out
);
    timeunit 1ns;
    timeprecision 1ps;

    import jse_pkg::*;

    localparam int         UserErr    = 0;
    localparam int         UserEos    = 1;
    localparam logic [7:0] Lead2Lo    = 8'hC2;
    localparam logic [7:0] Lead2Hi    = 8'hDF;
    localparam logic [7:0] Lead3Lo    = 8'hE0;
    localparam logic [7:0] Lead3Hi    = 8'hEF;
    localparam logic [7:0] LeadSurr   = 8'hED;
    localparam logic [7:0] Lead4Lo    = 8'hF0;
    localparam logic [7:0] Lead4Hi    = 8'hF4;
    localparam logic [7:0] ContLo     = 8'h80;
    localparam logic [7:0] ContHi     = 8'hBF;
    localparam logic [20:0] BmpTop    = 21'h00FFFF;

    typedef struct {
        logic [7:0] data;
        logic       run_end;
        logic       err;
        logic       eos;
    } escaped_t;

    escaped_t    escaped_q[$];
    logic [7:0]  run_bytes[$];

    logic        esc_mode;
    logic        in_discard;
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [20:0] cp_acc;
    logic [23:0] held;
    logic [7:0]  lead;

    int fails;
    int n_in;
    int n_out;
    int n_err;

    function automatic void add_byte(input logic [7:0] v);
        run_bytes.insert(run_bytes.size(), v);
    endfunction

    function automatic void add_word(input escaped_t v);
        escaped_q.insert(escaped_q.size(), v);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h57 + {4'd0, nib};
    endfunction

    function automatic void add_u_escape(input logic [15:0] unit);
        add_byte(ChBslash);
        add_byte(ChLowU);
        add_byte(nibble_char(unit[15:12]));
        add_byte(nibble_char(unit[11:8]));
        add_byte(nibble_char(unit[7:4]));
        add_byte(nibble_char(unit[3:0]));
    endfunction

    function automatic void drop_sequence();
        cont_left = '0;
        seq_len   = '0;
        cp_acc    = '0;
        held      = '0;
        lead      = '0;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic fin);
        logic [7:0]  esc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [20:0] cp;
        logic [2:0]  len;
        int          prior;
        bit          bad;
        escaped_t    w;
        bad = 1'b0;
        len = '0;
        run_bytes.delete();
        if (in_discard) begin
            if (fin) in_discard = 1'b0;
            return;
        end
        if (cont_left == 2'd0) begin
            case (b)
                ChQuote:  esc = ChQuote;
                ChBslash: esc = ChBslash;
                CtlBs:    esc = ChLowB;
                CtlFf:    esc = ChLowF;
                CtlNl:    esc = ChLowN;
                CtlCr:    esc = ChLowR;
                CtlTab:   esc = ChLowT;
                default:  esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
                add_byte(ChBslash);
                add_byte(esc);
            end else if (b < CtlLimit) begin
                add_u_escape({8'h00, b});
            end else if (b < AsciiLimit) begin
                add_byte(b);
            end else begin
                if (b >= Lead2Lo && b <= Lead2Hi) begin
                    len = 3'd2;
                    cp_acc = {16'd0, b[4:0]};
                end else if (b >= Lead3Lo && b <= Lead3Hi) begin
                    len = 3'd3;
                    cp_acc = {17'd0, b[3:0]};
                end else if (b >= Lead4Lo && b <= Lead4Hi) begin
                    len = 3'd4;
                    cp_acc = {18'd0, b[2:0]};
                end else begin
                    bad = 1'b1;
                end
                if (!bad && fin) bad = 1'b1;
                if (!bad) begin
                    seq_len   = len;
                    cont_left = 2'(len - 3'd1);
                    lead      = b;
                    held      = {16'd0, b};
                end
            end
        end else begin
            lo = ContLo;
            hi = ContHi;
            if ((cont_left + 3'd1) == seq_len) begin
                if (lead == Lead3Lo) lo = 8'hA0;
                else if (lead == LeadSurr) hi = 8'h9F;
                else if (lead == Lead4Lo) lo = 8'h90;
                else if (lead == Lead4Hi) hi = 8'h8F;
            end
            if (b < lo || b > hi) begin
                bad = 1'b1;
            end else begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_left = 2'(cont_left - 2'd1);
                if (cont_left != 2'd0) begin
                    if (fin) bad = 1'b1;
                    else held = {held[15:0], b};
                end else begin
                    if (esc_mode) begin
                        if (cp_acc <= BmpTop) begin
                            add_u_escape(cp_acc[15:0]);
                        end else begin
                            cp = cp_acc - PlaneOne;
                            add_u_escape(SurrHiBase + {6'd0, cp[19:10]});
                            add_u_escape(SurrLoBase + {6'd0, cp[9:0]});
                        end
                    end else begin
                        prior = int'(seq_len) - 1;
                        for (int k = 0; k < prior; k++) begin
                            add_byte(held[8 * (prior - 1 - k) +: 8]);
                        end
                        add_byte(b);
                    end
                    drop_sequence();
                end
            end
        end
        if (bad) begin
            drop_sequence();
            in_discard = !fin;
            w.data = 8'h00;
            w.run_end = 1'b1;
            w.err = 1'b1;
            w.eos = 1'b1;
            add_word(w);
            return;
        end
        foreach (run_bytes[i]) begin
            w.data    = run_bytes[i];
            w.run_end = (i == run_bytes.size() - 1);
            w.err     = 1'b0;
            w.eos     = (i == run_bytes.size() - 1) && fin;
            add_word(w);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        escaped_t want;
        if (!aresetn) begin
            esc_mode   = 1'b0;
            in_discard = 1'b0;
            drop_sequence();
            escaped_q.delete();
            fails = 0;
            n_in  = 0;
            n_out = 0;
            n_err = 0;
        end else begin
            if (cfg_wr_en) esc_mode = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                n_out++;
                if (m_tuser[UserErr] === 1'b1) n_err++;
                if (escaped_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word: expected none, actual %h/%b/%b",
                             $time, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = escaped_q.pop_front();
                    check_field("out_byte", want.data, m_tdata);
                    check_field("last_of_run", {7'd0, want.run_end}, {7'd0, m_tlast});
                    check_field("error", {7'd0, want.err}, {7'd0, m_tuser[UserErr]});
                    check_field("end_of_string", {7'd0, want.eos}, {7'd0, m_tuser[UserEos]});
                end
            end
            if (s_tvalid && s_tready) begin
                n_in++;
                predict_word(s_tdata, s_tlast);
            end
        end
        fail_count <= fails;
        pending    <= escaped_q.size();
        words_in   <= n_in;
        words_out  <= n_out;
        errors_out <= n_err;
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives string bytes into the json string escaper under both escape modes
// and several pacing mixes on both streams; escape_checker does the scoring
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int PhaseBytes = 22;
    localparam int SettleCyc  = 16;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    int fail_count;
    int pending;
    int words_in;
    int words_out;
    int errors_out;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int sent_bytes;

    logic [7:0] str_bytes[$];

    json_string_escaper i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    escape_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending),
        .words_in    (words_in),
        .words_out   (words_out),
        .errors_out  (errors_out)
    );

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
    end

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout with %0d words still expected", $time, pending);
            $display("** json_string_escaper: FAILED **");
            $finish;
        end
    end

    function automatic void add_str_byte(input logic [7:0] v);
        str_bytes.insert(str_bytes.size(), v);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_bytes++;
    endtask

    task automatic send_string();
        foreach (str_bytes[i]) send_word(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // stop sending until every expected word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        drain();
        repeat (SettleCyc) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // utf-8 encoding of a code point of the given length, first nbytes only
    task automatic push_seq(input int len, input int nbytes);
        logic [20:0] cp;
        logic [7:0]  enc[4];
        if ($urandom_range(3) == 0) begin
            case (len)
                2: cp = $urandom_range(1) ? 21'h80 : 21'h7FF;
                3: case ($urandom_range(3))
                       0: cp = 21'h800;
                       1: cp = 21'hD7FF;
                       2: cp = 21'hE000;
                       default: cp = 21'hFFFF;
                   endcase
                default: case ($urandom_range(3))
                       0: cp = 21'h10000;
                       1: cp = 21'h40000;
                       2: cp = 21'hFFFFF;
                       default: cp = 21'h10FFFF;
                   endcase
            endcase
        end else begin
            case (len)
                2: cp = 21'($urandom_range(21'h7FF, 21'h80));
                3: begin
                    cp = 21'($urandom_range(21'hFFFF, 21'h800));
                    if (cp[15:11] == 5'b11011) cp = cp ^ 21'h2000;
                end
                default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            endcase
        end
        case (len)
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < nbytes; i++) add_str_byte(enc[i]);
    endtask

    task automatic push_broken();
        int len;
        case ($urandom_range(5))
            0: begin
                add_str_byte(8'hE0);
                add_str_byte(8'($urandom_range(8'h9F, 8'h80)));
            end
            1: begin
                add_str_byte(8'hED);
                add_str_byte(8'($urandom_range(8'hBF, 8'hA0)));
            end
            2: begin
                add_str_byte(8'hF0);
                add_str_byte(8'($urandom_range(8'h8F, 8'h80)));
            end
            3: begin
                add_str_byte(8'hF4);
                add_str_byte(8'($urandom_range(8'hBF, 8'h90)));
            end
            default: begin
                len = $urandom_range(4, 2);
                push_seq(len, $urandom_range(len - 1, 1));
                add_str_byte($urandom_range(1) ? 8'($urandom_range(8'h7F, 8'h00))
                                               : 8'($urandom_range(8'hFF, 8'hC0)));
            end
        endcase
    endtask

    task automatic build_string();
        int r;
        int len;
        str_bytes.delete();
        repeat ($urandom_range(8, 1)) begin
            r = $urandom_range(99);
            if (r < 40) begin
                add_str_byte(8'($urandom_range(8'h7E, 8'h20)));
            end else if (r < 55) begin
                case ($urandom_range(3))
                    0: add_str_byte(8'h22);
                    1: add_str_byte(8'h5C);
                    2: add_str_byte(8'h7F);
                    default: add_str_byte(8'($urandom_range(8'h1F, 8'h00)));
                endcase
            end else if (r < 85) begin
                len = $urandom_range(4, 2);
                push_seq(len, len);
            end else if (r < 92) begin
                add_str_byte(8'($urandom));
            end else begin
                push_broken();
            end
        end
        // string cut short inside a sequence
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(4, 2);
            push_seq(len, $urandom_range(len - 1, 1));
        end
    endtask

    initial begin
        sent_bytes = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every escape class and raw copies
        write_mode(1'b0);
        str_bytes = '{8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h00,
                      8'h1F, 8'h7F, 8'hC3, 8'hA9};
        send_string();
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();

        // directed: surrogate pair, top of bmp below surrogates, bad lead,
        // dropped tail and a sequence truncated by the string end
        write_mode(1'b1);
        str_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hED, 8'h9F, 8'hBF, 8'hFF, 8'h41};
        send_string();
        str_bytes = '{8'hE2, 8'h82};
        send_string();

        for (int p = 0; p < 8; p++) begin
            write_mode(!p[0]);
            case (p >> 1)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 68; end
                default: begin send_idle_pct = 33; recv_stall_pct <= 33; end
            endcase
            sent_bytes = 0;
            while (sent_bytes < PhaseBytes) begin
                build_string();
                send_string();
                if ($urandom_range(11) == 0) drain();
            end
        end

        drain();
        repeat (2 * SettleCyc) @(posedge aclk);
        $display("run covered %0d string bytes, %0d escaped words, %0d utf-8 error words,",
                 words_in, words_out, errors_out);
        $display("both escape modes and four pacing mixes on the two streams");
        if (fail_count == 0 && pending == 0) begin
            $display("** json_string_escaper: PASSED **");
        end else begin
            $display("** json_string_escaper: FAILED **");
        end
        $finish;
    end

endmodule
